>>> hw/rtl/asoa_pkg.sv
// Package for the ADC scan oversample averager: sizes, register map,
// reset values of the scan sequence and the controller state type.
// No dependencies.
package asoa_pkg;

  localparam int CHANNELS    = 7;
  localparam int AVG_COUNT   = 4;
  localparam int OVERSAMPLE  = 4;

  localparam int RING_LEN    = AVG_COUNT * OVERSAMPLE;
  localparam int STORE_DEPTH = CHANNELS * RING_LEN;
  localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int RING_W      = (RING_LEN > 1) ? $clog2(RING_LEN) : 1;
  localparam int CNT_W       = $clog2(RING_LEN + 1);

  localparam int SAMPLE_W    = 12;
  localparam int SUM_W       = SAMPLE_W + $clog2(RING_LEN);
  localparam int PROD_W      = 2 * SUM_W + 1;
  localparam int SLOT_W      = 3;
  localparam int CHAN_W      = 5;
  localparam int AVG_W       = 14;
  localparam int AVG_MAX     = 16383;

  localparam int SEQ_REGS    = 8;
  localparam int SEQ_IDX_W   = 3;
  localparam int PADDR_W     = 5;
  localparam int PDATA_W     = 32;

  localparam int S_TDATA_W   = 16;
  localparam int M_TDATA_W   = 24;

  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_READ   = 1'b1;

  typedef logic [CHAN_W-1:0] chan_t;
  typedef chan_t seq_table_t [SEQ_REGS];

  localparam seq_table_t SEQ_RESET = '{
    5'd12, 5'd11, 5'd10, 5'd13, 5'd14, 5'd0, 5'd4, 5'd0
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_DIV_MUL,
    ST_DIV_FIX,
    ST_FINISH
  } ctrl_state_e;

endpackage

>>> hw/rtl/adc_scan_oversample_averager.sv
// Top level of the ADC scan oversample averager: sequencer, sample ring
// store, read-out averager and APB sequence registers.
// Depends on asoa_pkg.
//
// Usage:
//   Slave stream takes one request beat: tuser is the request kind (0 end of
//   conversion carrying a sample, 1 read of a slot average). A sample beat
//   stores the value at the current slot and ring position, advances the
//   scan and returns the converter channel for the next slot. A read beat
//   sums all stored samples of a slot and divides by the averaging count.
//   Master stream returns one result beat per request; tuser flags a read
//   of a slot at or beyond the channel count.
//   A sample beat and an invalid slot read go straight to the result
//   stage; a read first walks the slot's ring, one store read per cycle,
//   then runs a reciprocal divide (multiply, then correction).
//   One request is in work at a time; the next one is accepted while the
//   output register still holds an untaken result.
//   Reset clears the pointers, restores the scan sequence and marks every
//   store entry as zero through per-entry valid bits.
//   A stalled master side holds the result; the finished next result waits.
//   APB: sequence registers seq_slot_0..7 at byte addresses 4*i.
module adc_scan_oversample_averager
  import asoa_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // sample_value[11:0], slot_select[14:12], zero pad
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  // req_type[0]
  input  logic                 s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // next_channel[4:0], average_value[18:5], zero pad
  output logic [M_TDATA_W-1:0] m_axis_tdata,
  // slot_invalid[0]
  output logic                 m_axis_tuser,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PADDR_W-1:0]   paddr,
  input  logic [PDATA_W-1:0]   pwdata,
  output logic [PDATA_W-1:0]   prdata,
  output logic                 pready
);

  localparam logic [PROD_W-SUM_W-1:0] RECIP =
    (PROD_W-SUM_W)'((64'd1 << SUM_W) / AVG_COUNT);

  ctrl_state_e state_q, state_d;

  chan_t              seq_q [SEQ_REGS];
  logic [SLOT_W-1:0]  slot_q, slot_d;
  logic [RING_W-1:0]  ring_q, ring_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               rd_pend_q, rd_pend_d;
  logic [SLOT_W-1:0]  sel_q;
  logic [SUM_W-1:0]   acc_q;
  logic [PROD_W-1:0]  prod_q;

  logic [SAMPLE_W-1:0] mem_q [STORE_DEPTH];
  logic [STORE_DEPTH-1:0] vld_q;
  logic [SAMPLE_W-1:0] rdata_q;
  logic                vld_rd_q;

  chan_t              res_chan_q;
  logic [AVG_W-1:0]   res_avg_q;
  logic               res_inv_q;

  logic               m_valid_q;
  chan_t              m_chan_q;
  logic [AVG_W-1:0]   m_avg_q;
  logic               m_inv_q;

  logic               s_fire;
  logic               rd_en;
  logic               wr_en;
  logic               out_load;
  logic               cfg_wr;
  logic [ADDR_W-1:0]  rd_addr;
  logic [ADDR_W-1:0]  wr_addr;
  logic [SLOT_W-1:0]  req_sel;
  logic               req_ok;
  logic               slot_wrap;
  logic [SLOT_W-1:0]  slot_next;
  logic [RING_W-1:0]  ring_next;
  logic [PROD_W-SUM_W-1:0] quo;
  logic [PROD_W-SUM_W-1:0] rem;
  logic [PROD_W-SUM_W-1:0] quo_fix;

  assign s_fire  = s_axis_tvalid && s_axis_tready;
  assign req_sel = s_axis_tdata[SAMPLE_W +: SLOT_W];
  assign req_ok  = 32'(req_sel) < CHANNELS;

  assign slot_wrap = slot_q == SLOT_W'(CHANNELS - 1);
  assign slot_next = slot_wrap ? '0 : slot_q + SLOT_W'(1);
  assign ring_next = !slot_wrap ? ring_q :
                     (ring_q == RING_W'(RING_LEN - 1)) ? '0 : ring_q + RING_W'(1);

  assign wr_addr = ADDR_W'(slot_q) * ADDR_W'(RING_LEN) + ADDR_W'(ring_q);
  assign rd_addr = ADDR_W'(sel_q) * ADDR_W'(RING_LEN) + ADDR_W'(cnt_q[RING_W-1:0]);

  assign quo     = prod_q[PROD_W-1:SUM_W];
  assign rem     = (PROD_W-SUM_W)'(acc_q) - quo * (PROD_W-SUM_W)'(AVG_COUNT);
  assign quo_fix = (rem >= (PROD_W-SUM_W)'(AVG_COUNT)) ? quo + (PROD_W-SUM_W)'(1) : quo;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (s_fire) begin
          if (s_axis_tuser == REQ_READ && req_ok) state_d = ST_SUM;
          else                                    state_d = ST_FINISH;
        end
      end
      ST_SUM: begin
        if (cnt_q == CNT_W'(RING_LEN) && !rd_pend_q) state_d = ST_DIV_MUL;
      end
      ST_DIV_MUL: state_d = ST_DIV_FIX;
      ST_DIV_FIX: state_d = ST_FINISH;
      ST_FINISH: begin
        if (!m_valid_q || m_axis_tready) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // controller outputs
  always_comb begin
    s_axis_tready = 1'b0;
    rd_en         = 1'b0;
    out_load      = 1'b0;
    case (state_q)
      ST_IDLE:   s_axis_tready = 1'b1;
      ST_SUM:    rd_en = cnt_q < CNT_W'(RING_LEN);
      ST_FINISH: out_load = !m_valid_q || m_axis_tready;
      default: begin
        s_axis_tready = 1'b0;
      end
    endcase
  end

  assign wr_en     = s_fire && s_axis_tuser == REQ_SAMPLE;
  assign rd_pend_d = rd_en;
  assign cnt_d     = (state_q == ST_IDLE) ? '0 : rd_en ? cnt_q + CNT_W'(1) : cnt_q;
  assign slot_d    = wr_en ? slot_next : slot_q;
  assign ring_d    = wr_en ? ring_next : ring_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      slot_q    <= '0;
      ring_q    <= '0;
      cnt_q     <= '0;
      rd_pend_q <= 1'b0;
      m_valid_q <= 1'b0;
      vld_q     <= '0;
    end else begin
      state_q   <= state_d;
      slot_q    <= slot_d;
      ring_q    <= ring_d;
      cnt_q     <= cnt_d;
      rd_pend_q <= rd_pend_d;
      if (wr_en) vld_q[wr_addr] <= 1'b1;
      if (out_load)           m_valid_q <= 1'b1;
      else if (m_axis_tready) m_valid_q <= 1'b0;
    end
  end

  // sample store
  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= s_axis_tdata[SAMPLE_W-1:0];
    if (rd_en) begin
      rdata_q  <= mem_q[rd_addr];
      vld_rd_q <= vld_q[rd_addr];
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        sel_q <= req_sel;
        acc_q <= '0;
        if (s_axis_tuser == REQ_SAMPLE) begin
          res_chan_q <= seq_q[slot_next];
          res_avg_q  <= '0;
          res_inv_q  <= 1'b0;
        end else begin
          res_chan_q <= '0;
          res_avg_q  <= '0;
          res_inv_q  <= !req_ok;
        end
      end
      ST_SUM: begin
        if (rd_pend_q && vld_rd_q) acc_q <= acc_q + SUM_W'(rdata_q);
      end
      ST_DIV_MUL: prod_q <= PROD_W'(acc_q) * PROD_W'(RECIP);
      ST_DIV_FIX: begin
        res_avg_q <= (quo_fix > (PROD_W-SUM_W)'(AVG_MAX)) ? AVG_W'(AVG_MAX)
                                                          : AVG_W'(quo_fix);
      end
      default: begin
        acc_q <= acc_q;
      end
    endcase
    if (out_load) begin
      m_chan_q <= res_chan_q;
      m_avg_q  <= res_avg_q;
      m_inv_q  <= res_inv_q;
    end
  end

  // sequence registers
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign prdata = PDATA_W'(seq_q[paddr[PADDR_W-1:2]]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q <= SEQ_RESET;
    end else if (cfg_wr) begin
      seq_q[paddr[PADDR_W-1:2]] <= pwdata[CHAN_W-1:0];
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {(M_TDATA_W-CHAN_W-AVG_W)'(0), m_avg_q, m_chan_q};
  assign m_axis_tuser  = m_inv_q;

`ifndef NO_ASSERTIONS
  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(slot_q) < CHANNELS)
    else $error("slot pointer out of range");

  a_ring_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(ring_q) < RING_LEN)
    else $error("ring pointer out of range");

  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_pend_q |-> state_q == ST_SUM && cnt_q != '0)
    else $error("store read pending outside the ring walk");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
    else $error("invalid slot read carries data");
`endif

endmodule
